### hdl/ilam_pkg.sv
// ----------------------------------------------------------------------------
// ilam_pkg
// Shared types and constants for the IPv4 local address match core.
// ----------------------------------------------------------------------------
package ilam_pkg;

  localparam int WORD_W          = 32;
  localparam int INDEX_W         = 3;
  localparam int OP_W            = 3;
  localparam int DEFAULT_ENTRIES = 8;

  localparam logic [WORD_W-1:0] LIMITED_BCAST = '1;
  localparam logic [3:0]        MCAST_PREFIX  = 4'hE;
  localparam logic [7:0]        LOOPBACK_NET  = 8'd127;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP      = 3'd0,
    OP_ADD         = 3'd1,
    OP_REMOVE      = 3'd2,
    OP_SET_ADDR    = 3'd3,
    OP_SET_MASK    = 3'd4,
    OP_SET_BCAST   = 3'd5,
    OP_SET_ANYCAST = 3'd6,
    OP_NOP         = 3'd7
  } op_t;

  // One beat as it travels down the cell chain
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [INDEX_W-1:0]  idx;
    logic [WORD_W-1:0]   value;
    logic                chk_bc;
    logic                chk_mc;
    logic                is_local;
    logic                status;
  } beat_t;

endpackage

### hdl/ilam_req_if.sv
// ----------------------------------------------------------------------------
// ilam_req_if
// Request channel: one table operation or lookup per beat.
// ----------------------------------------------------------------------------
interface ilam_req_if;
  logic                         valid;
  logic                         ready;
  logic [ilam_pkg::OP_W-1:0]    operation;
  logic [ilam_pkg::INDEX_W-1:0] entry_index;
  logic [ilam_pkg::WORD_W-1:0]  value;
  logic                         bcast_check;
  logic                         mcast_check;

  modport source (output valid, operation, entry_index, value, bcast_check,
                  mcast_check, input ready);
  modport sink   (input valid, operation, entry_index, value, bcast_check,
                  mcast_check, output ready);
endinterface

### hdl/ilam_rsp_if.sv
// ----------------------------------------------------------------------------
// ilam_rsp_if
// Response channel: lookup result and table status per beat.
// ----------------------------------------------------------------------------
interface ilam_rsp_if;
  logic valid;
  logic ready;
  logic is_local;
  logic status;

  modport source (output valid, is_local, status, input ready);
  modport sink   (input valid, is_local, status, output ready);
endinterface

### hdl/ilam_special.sv
// ----------------------------------------------------------------------------
// ilam_special
// Seeds a fresh beat: fixed special-address checks and the default status.
// ----------------------------------------------------------------------------
module ilam_special (
  input  ilam_pkg::beat_t raw,
  output ilam_pkg::beat_t seeded
);
  import ilam_pkg::*;

  logic bcast_hit;
  logic mcast_hit;
  logic loop_hit;

  // limited broadcast, multicast 224/4, loopback 127/8
  assign bcast_hit = raw.chk_bc && (raw.value == LIMITED_BCAST);
  assign mcast_hit = raw.chk_mc && (raw.value[WORD_W-1 -: 4] == MCAST_PREFIX);
  assign loop_hit  = (raw.value[WORD_W-1 -: 8] == LOOPBACK_NET);

  // table ops start as "not present"; the addressed cell clears it
  always_comb begin
    seeded          = raw;
    seeded.is_local = 1'b0;
    seeded.status   = 1'b0;
    case (raw.op) inside
      OP_LOOKUP: begin
        seeded.is_local = bcast_hit || mcast_hit || loop_hit;
      end
      OP_ADD, OP_REMOVE, OP_SET_ADDR, OP_SET_MASK, OP_SET_BCAST,
      OP_SET_ANYCAST: begin
        seeded.status = 1'b1;
      end
      default: begin
        seeded.status = 1'b0;
      end
    endcase
  end

endmodule

### hdl/ilam_cell.sv
// ----------------------------------------------------------------------------
// ilam_cell
// One table slot of the chain: holds its entry, applies the passing beat to
// it and forwards the beat, with its match and status, to the next cell.
// ----------------------------------------------------------------------------
module ilam_cell #(
  parameter int CELL_ID = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  ilam_pkg::beat_t beat_in,
  output ilam_pkg::beat_t beat_out
);
  import ilam_pkg::*;

  localparam bit                 ADDRESSABLE = CELL_ID < (1 << INDEX_W);
  localparam logic [INDEX_W-1:0] MY_INDEX    = INDEX_W'(CELL_ID);

  logic              entry_valid;
  logic [WORD_W-1:0] entry_address;
  logic [WORD_W-1:0] entry_mask;
  logic [WORD_W-1:0] entry_broadcast;
  logic [WORD_W-1:0] entry_anycast;

  logic  hit;
  logic  table_op;
  logic  present;
  logic  dst_match;
  logic  do_write;
  beat_t beat_next;

  assign hit      = ADDRESSABLE && (beat_in.idx == MY_INDEX);
  assign table_op = (beat_in.op != OP_LOOKUP) && (beat_in.op != OP_NOP);
  assign present  = (beat_in.op == OP_ADD) || entry_valid;
  assign do_write = en && beat_in.valid && hit && table_op && present;

  // lookup against this slot
  assign dst_match = entry_valid &&
                     ((beat_in.value == entry_address) ||
                      (beat_in.chk_bc &&
                       ((beat_in.value == entry_anycast) ||
                        (beat_in.value == (entry_address & entry_mask)) ||
                        (beat_in.value == entry_broadcast))));

  // beat update
  always_comb begin
    beat_next = beat_in;
    if (beat_in.op == OP_LOOKUP && dst_match) begin
      beat_next.is_local = 1'b1;
    end
    if (hit && table_op && present) begin
      beat_next.status = 1'b0;
    end
  end

  // slot valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (do_write) begin
      unique case (beat_in.op)
        OP_ADD:    entry_valid <= 1'b1;
        OP_REMOVE: entry_valid <= 1'b0;
        default:   entry_valid <= entry_valid;
      endcase
    end
  end

  // slot words, no reset
  always_ff @(posedge clk) begin
    if (do_write) begin
      unique case (beat_in.op)
        OP_ADD: begin
          entry_address   <= '0;
          entry_mask      <= '0;
          entry_broadcast <= '0;
          entry_anycast   <= '0;
        end
        OP_SET_ADDR: entry_address <= beat_in.value;
        OP_SET_MASK: begin
          entry_mask      <= beat_in.value;
          entry_broadcast <= entry_address | ~beat_in.value;
        end
        OP_SET_BCAST:   entry_broadcast <= beat_in.value;
        OP_SET_ANYCAST: entry_anycast   <= beat_in.value;
        default: ;
      endcase
    end
  end

  // stage register toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_out.valid <= 1'b0;
    end else if (en) begin
      beat_out <= beat_next;
    end
  end

  a_add_sets_valid: assert property (@(posedge clk) disable iff (rst)
    do_write && beat_in.op == OP_ADD |=> entry_valid)
    else $error("add did not mark slot valid");

  a_remove_clears_valid: assert property (@(posedge clk) disable iff (rst)
    do_write && beat_in.op == OP_REMOVE |=> !entry_valid)
    else $error("remove did not clear slot");

  a_write_status_ok: assert property (@(posedge clk) disable iff (rst)
    do_write |=> beat_out.valid && !beat_out.status)
    else $error("applied table op left status set");

endmodule

### hdl/ipv4_local_address_match_core.sv
// ----------------------------------------------------------------------------
// ipv4_local_address_match_core
// IPv4 local destination check over a chain of table-slot cells.
//
//   channel  dir  beat contents
//   req      in   operation, entry_index, value, bcast_check,
//                 mcast_check
//   rsp      out  is_local, status
//
// Each beat walks the chain one cell per cycle while the chain advances,
// and one beat is accepted per cycle unless rsp holds a result; the chain
// depth sets the latency. Beats stay in order, so each one sees every
// earlier update. Reset clears slot valid bits and stage valid flags.
// A held result on rsp freezes the whole chain and drops req.ready.
// ----------------------------------------------------------------------------
module ipv4_local_address_match_core #(
  parameter int ENTRIES = ilam_pkg::DEFAULT_ENTRIES
) (
  input logic        clk,
  input logic        rst,
  ilam_req_if.sink   req,
  ilam_rsp_if.source rsp
);
  import ilam_pkg::*;

  logic  advance;
  beat_t raw;
  beat_t chain [ENTRIES+1];

  // whole chain moves unless the output beat is held
  assign advance   = !chain[ENTRIES].valid || rsp.ready;
  assign req.ready = advance;

  // pack request beat
  always_comb begin
    raw          = '0;
    raw.valid    = req.valid;
    raw.op       = op_t'(req.operation);
    raw.idx      = req.entry_index;
    raw.value    = req.value;
    raw.chk_bc   = req.bcast_check;
    raw.chk_mc   = req.mcast_check;
  end

  ilam_special u_special (
    .raw    (raw),
    .seeded (chain[0])
  );

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    ilam_cell #(.CELL_ID(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .beat_in  (chain[k]),
      .beat_out (chain[k+1])
    );
  end

  assign rsp.valid    = chain[ENTRIES].valid;
  assign rsp.is_local = chain[ENTRIES].is_local;
  assign rsp.status   = chain[ENTRIES].status;

  a_local_only_lookup: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && chain[ENTRIES].op != OP_LOOKUP |-> !rsp.is_local)
    else $error("is_local set on a table op");

  a_lookup_status_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (chain[ENTRIES].op == OP_LOOKUP || chain[ENTRIES].op == OP_NOP)
    |-> !rsp.status)
    else $error("status set on lookup or no-op");

  a_loopback_local: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && chain[ENTRIES].op == OP_LOOKUP &&
    chain[ENTRIES].value[WORD_W-1 -: 8] == LOOPBACK_NET |-> rsp.is_local)
    else $error("loopback destination not local");

endmodule
